### rtl/mme_pkg.sv
// Package for the matrix multiply engine: sizes, commands, register indexes.
// No dependencies.
`default_nettype none
package mme_pkg;
  localparam int MAX_DIM = 8;
  localparam int DATA_WIDTH = 16;
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W = PROD_W + IDX_W + 1;
  localparam int SIZE_W = 4;

  localparam logic [1:0] CMD_LEFT = 2'd0;
  localparam logic [1:0] CMD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_INNER = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Token passed down the cell chain.
  typedef struct packed {
    logic vld;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W:0] k;
    logic [IDX_W:0] nk;
    logic last;
    logic [ACC_W-1:0] acc;
  } tok_t;

  // Clamp a size register to 1..MAX_DIM.
  function automatic logic [IDX_W:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [IDX_W:0] s;
    if (r == '0) s = (IDX_W+1)'(1);
    else if (32'(r) > MAX_DIM) s = (IDX_W+1)'(MAX_DIM);
    else s = (IDX_W+1)'(r);
    return s;
  endfunction
endpackage
`default_nettype wire

### rtl/mme_cell.sv
// One multiply-accumulate cell: holds one left column and one right row,
// and adds its left*right term to the passing token. Depends on mme_pkg.
`default_nettype none
module mme_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic left_we,
  input  wire logic right_we,
  input  wire logic [mme_pkg::IDX_W-1:0] left_addr,
  input  wire logic [mme_pkg::IDX_W-1:0] right_addr,
  input  wire logic [mme_pkg::DATA_WIDTH-1:0] wr_data,
  input  wire mme_pkg::tok_t tok_in,
  output mme_pkg::tok_t tok_out
);
  logic [mme_pkg::DATA_WIDTH-1:0] left_col [mme_pkg::MAX_DIM];
  logic [mme_pkg::DATA_WIDTH-1:0] right_row [mme_pkg::MAX_DIM];
  mme_pkg::tok_t tok;
  logic signed [mme_pkg::DATA_WIDTH-1:0] a, b;
  logic signed [mme_pkg::PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (left_we) left_col[left_addr] <= wr_data;
    if (right_we) right_row[right_addr] <= wr_data;
  end

  // capture the token with its operands; hold while the chain is stalled
  always_ff @(posedge clk) begin
    if (rst) tok.vld <= 1'b0;
    else if (en) begin
      tok <= tok_in;
      a <= left_col[tok_in.row];
      b <= right_row[tok_in.col];
    end
  end

  assign prod = a * b;

  always_comb begin
    tok_out = tok;
    // add only the terms inside the inner size
    if (tok.k < tok.nk)
      tok_out.acc = tok.acc + mme_pkg::ACC_W'(prod);
    tok_out.k = tok.k + 1'b1;
  end
endmodule
`default_nettype wire

### rtl/matrix_multiply_engine_core.sv
// Top level: size registers, issue sequencer, cell chain and output register.
// Depends on mme_pkg and mme_cell.
//
//  channel | signals                                         | dir
//  in      | valid ready cmd row_index col_index element_value | in
//  out     | out_valid out_ready out_row out_col product_value last | out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | in
//
// A load writes one element into the cell stores. A compute of M = rows x cols
// elements issues one element per cycle, while the output is not stalled, into
// a chain of MAX_DIM cells, each adding one inner term; the input and config
// ports stay closed until the last result has left the output register.
// Issue and chain hold while the output register is full and not taken.
// Reset clears control; stores are undefined until written.
`default_nettype none
module matrix_multiply_engine_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid,
  output logic ready,
  input  wire logic [1:0] cmd,
  input  wire logic [2:0] row_index,
  input  wire logic [2:0] col_index,
  input  wire logic signed [15:0] element_value,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [2:0] out_row,
  output logic [2:0] out_col,
  output logic signed [31:0] product_value,
  output logic last,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data
);
  localparam int N = mme_pkg::MAX_DIM;
  localparam int IW = mme_pkg::IDX_W;
  localparam int DW = mme_pkg::DATA_WIDTH;

  logic [mme_pkg::SIZE_W-1:0] rows_used, inner_used, cols_used;
  logic busy, issuing;
  logic [IW-1:0] ir, ic;
  logic [IW:0] nr, nk, nc;
  logic [IW:0] inflight, inflight_next;
  mme_pkg::tok_t issue_tok;
  mme_pkg::tok_t chain [N+1];
  logic stall, go, take;
  logic load_left, load_right;
  logic [DW-1:0] val;

  assign nr = mme_pkg::eff_size(rows_used);
  assign nk = mme_pkg::eff_size(inner_used);
  assign nc = mme_pkg::eff_size(cols_used);
  assign cfg_ready = !busy;
  assign ready = !busy;
  assign val = DW'(element_value);
  // whole chain advances together; hold when output full and not taken
  assign stall = out_valid && !out_ready;
  assign go = !stall;
  assign take = out_valid && out_ready;
  assign load_left = valid && ready && cmd == mme_pkg::CMD_LEFT
                     && {1'b0, row_index} < nr && {1'b0, col_index} < nk;
  assign load_right = valid && ready && cmd == mme_pkg::CMD_RIGHT
                      && {1'b0, row_index} < nk && {1'b0, col_index} < nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used <= 4'd8; inner_used <= 4'd8; cols_used <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mme_pkg::REG_ROWS: rows_used <= cfg_data;
        mme_pkg::REG_INNER: inner_used <= cfg_data;
        mme_pkg::REG_COLS: cols_used <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    inflight_next = inflight;
    if (issue_tok.vld) inflight_next = inflight_next + 1'b1;
    if (take) inflight_next = inflight_next - 1'b1;
  end

  // issue sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; issuing <= 1'b0; ir <= '0; ic <= '0; inflight <= '0;
    end else begin
      inflight <= inflight_next;
      if (valid && ready && cmd == mme_pkg::CMD_COMPUTE) begin
        busy <= 1'b1; issuing <= 1'b1; ir <= '0; ic <= '0;
      end else if (go && issuing) begin
        if ({1'b0, ic} == nc - 1'b1) begin
          ic <= '0;
          if ({1'b0, ir} == nr - 1'b1) issuing <= 1'b0;
          else ir <= ir + 1'b1;
        end else ic <= ic + 1'b1;
      end
      // release the input once the last result has left
      if (busy && !issuing && inflight_next == '0)
        busy <= 1'b0;
    end
  end

  always_comb begin
    issue_tok.vld = issuing && go;
    issue_tok.row = ir;
    issue_tok.col = ic;
    issue_tok.k = '0;
    issue_tok.nk = nk;
    issue_tok.last = ({1'b0, ir} == nr - 1'b1) && ({1'b0, ic} == nc - 1'b1);
    issue_tok.acc = '0;
  end

  assign chain[0] = issue_tok;

  // cell g holds left column g and right row g
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      mme_cell u_cell (
        .clk(clk), .rst(rst), .en(go),
        .left_we(load_left && col_index == IW'(g)),
        .right_we(load_right && row_index == IW'(g)),
        .left_addr(row_index), .right_addr(col_index), .wr_data(val),
        .tok_in(chain[g]), .tok_out(chain[g+1])
      );
    end
  endgenerate

  // output register with saturation
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (go) begin
      out_valid <= chain[N].vld;
      out_row <= chain[N].row;
      out_col <= chain[N].col;
      last <= chain[N].last;
      if ($signed(chain[N].acc) > $signed(mme_pkg::ACC_W'(32'sh7fffffff)))
        product_value <= 32'sh7fffffff;
      else if ($signed(chain[N].acc) < -$signed(mme_pkg::ACC_W'(33'sh080000000)))
        product_value <= 32'sh80000000;
      else product_value <= chain[N].acc[31:0];
    end
  end
endmodule
`default_nettype wire

### rtl/mme_checker.sv
// Port checker for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg and the top level's ports.
`default_nettype none
module mme_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic valid,
  input wire logic ready,
  input wire logic [1:0] cmd,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic last,
  input wire logic [31:0] product_value
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(product_value))
    else $error("output request dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    valid && ready && cmd == mme_pkg::CMD_COMPUTE |=> !ready)
    else $error("request taken during compute");
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !ready)
    else $error("input open while results are pending");
endmodule
bind matrix_multiply_engine_core mme_checker u_chk (
  .clk(clk), .rst(rst), .valid(valid), .ready(ready), .cmd(cmd),
  .out_valid(out_valid), .out_ready(out_ready), .last(last),
  .product_value(product_value)
);
`default_nettype wire
